### hw/rtl/uer_pkg.sv
package uer_pkg;

    // Widths fixed by the register map and sensor timing
    localparam int TRIG_W    = 10;
    localparam int PERIOD_W  = 8;
    localparam int TIME_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DIST_BITS_DEFAULT = 10;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 2'd2;

    // Register reset values
    localparam logic [TRIG_W-1:0]   TRIGGER_WIDTH_RST = 10'd100;
    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 8'd58;
    localparam logic [TIME_W-1:0]   TIMEOUT_RST       = 16'd1000;

    // Saturation limits
    localparam logic [TRIG_W-1:0] TRIG_COUNT_MAX = {TRIG_W{1'b1}};
    localparam logic [TIME_W-1:0] ELAPSED_MAX    = {TIME_W{1'b1}};

    // Item opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TRIG  = 2'd1,
        PH_WAIT  = 2'd2,
        PH_COUNT = 2'd3
    } phase_t;

    typedef struct packed {
        logic [TRIG_W-1:0]   trigger_width_us;
        logic [PERIOD_W-1:0] sample_period_us;
        logic [TIME_W-1:0]   timeout_us;
    } cfg_t;

    typedef struct packed {
        logic trigger_level;
        logic busy_res;
        logic done_res;
        logic no_response;
    } res_flags_t;

endpackage

### hw/rtl/uer_cfg_regs.sv
module uer_cfg_regs
    import uer_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TRIGGER_WIDTH: cfg_next.trigger_width_us = cfg_data[TRIG_W-1:0];
                REG_SAMPLE_PERIOD: cfg_next.sample_period_us = cfg_data[PERIOD_W-1:0];
                REG_TIMEOUT:       cfg_next.timeout_us       = cfg_data[TIME_W-1:0];
                default:           cfg_next = cfg_reg;  // unmapped index: drop
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_width_us <= TRIGGER_WIDTH_RST;
            cfg_reg.sample_period_us <= SAMPLE_PERIOD_RST;
            cfg_reg.timeout_us       <= TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/uer_core.sv
module uer_core
    import uer_pkg::*;
#(
    parameter int DIST_BITS = DIST_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 opcode,
    input  logic                 echo_level,
    input  cfg_t                 cfg,
    output res_flags_t           res_flags,
    output logic [DIST_BITS-1:0] res_dist
);

    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    phase_t               phase_reg,     phase_next;
    logic [TRIG_W-1:0]    trig_cnt_reg,  trig_cnt_next;
    logic [PERIOD_W-1:0]  prescale_reg,  prescale_next;
    logic [TIME_W-1:0]    elapsed_reg,   elapsed_next;
    logic [DIST_BITS-1:0] samples_reg,   samples_next;

    logic [TRIG_W-1:0]    trig_cnt_inc;
    logic [TIME_W-1:0]    elapsed_inc;
    logic [PERIOD_W:0]    prescale_inc;
    logic                 sample_now;

    assign trig_cnt_inc = (trig_cnt_reg < TRIG_COUNT_MAX) ? trig_cnt_reg + 1'b1 : trig_cnt_reg;
    assign elapsed_inc  = (elapsed_reg < ELAPSED_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign prescale_inc = {1'b0, prescale_reg} + 1'b1;
    assign sample_now   = (prescale_reg == '0);

    // Next state
    always_comb
    begin
        phase_next    = phase_reg;
        trig_cnt_next = trig_cnt_reg;
        prescale_next = prescale_reg;
        elapsed_next  = elapsed_reg;
        samples_next  = samples_reg;
        if (opcode == OP_START)
        begin
            phase_next    = PH_TRIG;
            trig_cnt_next = '0;
            prescale_next = '0;
            elapsed_next  = '0;
            samples_next  = '0;
        end
        else if (phase_reg != PH_IDLE)
        begin
            elapsed_next = elapsed_inc;
            if (phase_reg == PH_TRIG)
            begin
                trig_cnt_next = trig_cnt_inc;
                if (trig_cnt_inc >= cfg.trigger_width_us)
                begin
                    phase_next    = PH_WAIT;
                    prescale_next = '0;
                end
            end
            else
            begin
                // wrap at the period; a zero period samples every tick
                if (prescale_inc >= {1'b0, cfg.sample_period_us} || prescale_inc[PERIOD_W])
                    prescale_next = '0;
                else
                    prescale_next = prescale_inc[PERIOD_W-1:0];
                if (sample_now)
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        if (echo_level)
                        begin
                            phase_next   = PH_COUNT;
                            samples_next = DIST_BITS'(1);
                        end
                        else if (elapsed_inc >= cfg.timeout_us)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (echo_level)
                    begin
                        if (samples_reg < DIST_MAX)
                            samples_next = samples_reg + 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
        end
    end

    // Result word
    always_comb
    begin
        res_flags.trigger_level = (phase_next == PH_TRIG);
        res_flags.busy_res      = (phase_next != PH_IDLE);
        res_flags.done_res      = 1'b0;
        res_flags.no_response   = 1'b0;
        res_dist                = '0;
        if (opcode == OP_TICK && sample_now && phase_next == PH_IDLE)
        begin
            unique case (phase_reg)
                PH_WAIT:
                begin
                    res_flags.done_res    = 1'b1;
                    res_flags.no_response = 1'b1;
                end
                PH_COUNT:
                begin
                    res_flags.done_res = 1'b1;
                    res_dist           = samples_reg;
                end
                PH_IDLE, PH_TRIG:
                begin
                    res_flags.done_res = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            trig_cnt_reg <= '0;
            prescale_reg <= '0;
            elapsed_reg  <= '0;
            samples_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            trig_cnt_reg <= trig_cnt_next;
            prescale_reg <= prescale_next;
            elapsed_reg  <= elapsed_next;
            samples_reg  <= samples_next;
        end
    end

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_flags.done_res) |=> (phase_reg == PH_IDLE))
        else $error("finished measurement did not return to idle");

    a_dist_only_on_success: assert property (@(posedge clk) disable iff (!rst_n)
        (res_dist != '0) |-> (res_flags.done_res && !res_flags.no_response))
        else $error("distance reported without a successful finish");

    a_start_enters_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_START) |=> (phase_reg == PH_TRIG && elapsed_reg == '0))
        else $error("start did not restart the trigger phase");

endmodule

### hw/rtl/uer_skid.sv
module uer_skid
    import uer_pkg::*;
#(
    parameter int DIST_BITS = DIST_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  res_flags_t           push_flags,
    input  logic [DIST_BITS-1:0] push_dist,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output res_flags_t           out_flags,
    output logic [DIST_BITS-1:0] out_dist
);

    logic                 out_vld_reg;
    res_flags_t           out_flags_reg;
    logic [DIST_BITS-1:0] out_dist_reg;
    logic                 skid_vld_reg;
    res_flags_t           skid_flags_reg;
    logic [DIST_BITS-1:0] skid_dist_reg;
    logic                 take;

    assign take = out_vld_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (take)
                skid_vld_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!out_vld_reg || take)
                out_vld_reg <= 1'b1;
            else
                skid_vld_reg <= 1'b1;
        end
        else if (take)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // payload: advance skid into output, or load the new word
    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (take)
            begin
                out_flags_reg <= skid_flags_reg;
                out_dist_reg  <= skid_dist_reg;
            end
        end
        else if (push)
        begin
            if (!out_vld_reg || take)
            begin
                out_flags_reg <= push_flags;
                out_dist_reg  <= push_dist;
            end
            else
            begin
                skid_flags_reg <= push_flags;
                skid_dist_reg  <= push_dist;
            end
        end
    end

    assign full      = skid_vld_reg;
    assign out_valid = out_vld_reg;
    assign out_flags = out_flags_reg;
    assign out_dist  = out_dist_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid word held with empty output stage");

    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && out_stall))
        else $error("skid filled while output was free");

endmodule

### hw/rtl/ultrasonic_echo_ranger.sv
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+--------------------------------------------
// item     | item_valid / item_stall     | opcode, echo_level
// result   | res_valid / res_stall       | trigger_level, busy_res, done_res,
//          |                             | no_response, distance_cm
// config   | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// One word in, one result word out, one item per cycle sustained while item_stall
// is low; the result is registered in the output buffer as the item is taken.
// The range state (phase, trigger, prescale, elapsed, sample counters) updates
// in the same cycle the item is taken; the counter update sets the path.
// A two-entry output buffer absorbs one stalled result; item_stall rises only
// when both entries hold words, and it comes straight from a flop.
// Reset clears the measurement state to idle and the registers to their
// default timing (100 us trigger, 58 us per cm, 1000 us timeout).
module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int DIST_BITS = DIST_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic                  opcode,
    input  logic                  echo_level,

    output logic                  res_valid,
    input  logic                  res_stall,
    output logic                  trigger_level,
    output logic                  busy_res,
    output logic                  done_res,
    output logic                  no_response,
    output logic [DIST_BITS-1:0]  distance_cm,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                 cfg;
    res_flags_t           core_flags;
    logic [DIST_BITS-1:0] core_dist;
    res_flags_t           out_flags;
    logic                 buf_full;
    logic                 accept;

    // Registers take a write on any cycle
    assign cfg_ready = 1'b1;

    // Take an item whenever the output buffer has a free entry
    assign item_stall = buf_full;
    assign accept     = item_valid && !buf_full;

    uer_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uer_core #(
        .DIST_BITS (DIST_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .opcode     (opcode),
        .echo_level (echo_level),
        .cfg        (cfg),
        .res_flags  (core_flags),
        .res_dist   (core_dist)
    );

    // Hold results here while the consumer stalls
    uer_skid #(
        .DIST_BITS (DIST_BITS)
    ) u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_flags (core_flags),
        .push_dist  (core_dist),
        .full       (buf_full),
        .out_valid  (res_valid),
        .out_stall  (res_stall),
        .out_flags  (out_flags),
        .out_dist   (distance_cm)
    );

    assign trigger_level = out_flags.trigger_level;
    assign busy_res      = out_flags.busy_res;
    assign done_res      = out_flags.done_res;
    assign no_response   = out_flags.no_response;

endmodule
